[rtl/pfa_pkg.sv]
// Shared types, widths and control codes for the polygon fan area block.
package pfa_pkg;

    localparam int MAX_VERTICES = 256;
    localparam int CNT_W        = $clog2(MAX_VERTICES + 1);

    localparam int COORD_W = 16;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int PROD_W  = 2 * DIFF_W;
    localparam int CROSS_W = PROD_W + 1;
    localparam int MAG_W   = CROSS_W - 1;
    localparam int SQ_W    = 2 * MAG_W;
    localparam int ROOT_W  = 36;
    localparam int RAD_W   = 2 * ROOT_W;
    localparam int REM_W   = ROOT_W + 2;
    localparam int ITER_W  = $clog2(ROOT_W);
    localparam int DOT_W   = CROSS_W + COORD_W + 2;
    localparam int ACC_W   = 45;
    localparam int AREA_W  = 43;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic signed [DIFF_W-1:0]  t_diff;
    typedef logic signed [PROD_W-1:0]  t_prod;
    typedef logic signed [CROSS_W-1:0] t_cross;
    typedef logic        [MAG_W-1:0]   t_mag;
    typedef logic        [SQ_W-1:0]    t_sq;
    typedef logic        [RAD_W-1:0]   t_rad;
    typedef logic        [ROOT_W-1:0]  t_root;
    typedef logic        [REM_W-1:0]   t_rem;
    typedef logic        [ITER_W-1:0]  t_iter;
    typedef logic signed [DOT_W-1:0]   t_dot;
    typedef logic signed [ACC_W-1:0]   t_acc;
    typedef logic        [AREA_W-1:0]  t_area;
    typedef logic        [CNT_W-1:0]   t_cnt;

    localparam t_cnt  CNT_MAX      = t_cnt'(MAX_VERTICES);
    localparam t_cnt  CNT_TRIANGLE = t_cnt'(2);
    localparam t_cnt  CNT_MIN_POLY = t_cnt'(3);
    localparam t_iter ITER_LAST    = t_iter'(ROOT_W - 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIFF,
        S_MUL,
        S_CROSS,
        S_SQUARE,
        S_SUM,
        S_ROOT,
        S_ACC,
        S_FINISH
    } t_state;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_CAPTURE,
        CMD_DIFF,
        CMD_MUL,
        CMD_CROSS,
        CMD_SQUARE,
        CMD_SUM,
        CMD_ROOT,
        CMD_ACC,
        CMD_EMIT
    } t_cmd;

    typedef struct packed {
        logic full;       // vertex count has reached the maximum
        logic forms_tri;  // two or more vertices held
        logic last;       // captured item closes the polygon
        logic root_done;  // final square root step in progress
        logic out_free;   // output register can take a result this cycle
    } t_dp_status;

endpackage

[rtl/pfa_ctrl.sv]
// Sequencer for the polygon fan area block: issues one datapath command per cycle.
module pfa_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  pfa_pkg::t_dp_status i_status,
    output logic                o_in_stall,
    output pfa_pkg::t_cmd       o_cmd
);

    pfa_pkg::t_state r_state;
    pfa_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pfa_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pfa_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    if (i_status.full || !i_status.forms_tri) begin
                        n_state = pfa_pkg::S_FINISH;
                    end else begin
                        n_state = pfa_pkg::S_DIFF;
                    end
                end
            end
            pfa_pkg::S_DIFF:   n_state = pfa_pkg::S_MUL;
            pfa_pkg::S_MUL:    n_state = pfa_pkg::S_CROSS;
            pfa_pkg::S_CROSS:  n_state = pfa_pkg::S_SQUARE;
            pfa_pkg::S_SQUARE: n_state = pfa_pkg::S_SUM;
            pfa_pkg::S_SUM:    n_state = pfa_pkg::S_ROOT;
            pfa_pkg::S_ROOT: begin
                if (i_status.root_done) begin
                    n_state = pfa_pkg::S_ACC;
                end
            end
            pfa_pkg::S_ACC:    n_state = pfa_pkg::S_FINISH;
            pfa_pkg::S_FINISH: begin
                if (!i_status.last || i_status.out_free) begin
                    n_state = pfa_pkg::S_IDLE;
                end
            end
            default:           n_state = pfa_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall = (r_state != pfa_pkg::S_IDLE);
        o_cmd      = pfa_pkg::CMD_NONE;
        unique case (r_state)
            pfa_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd = pfa_pkg::CMD_CAPTURE;
                end
            end
            pfa_pkg::S_DIFF:   o_cmd = pfa_pkg::CMD_DIFF;
            pfa_pkg::S_MUL:    o_cmd = pfa_pkg::CMD_MUL;
            pfa_pkg::S_CROSS:  o_cmd = pfa_pkg::CMD_CROSS;
            pfa_pkg::S_SQUARE: o_cmd = pfa_pkg::CMD_SQUARE;
            pfa_pkg::S_SUM:    o_cmd = pfa_pkg::CMD_SUM;
            pfa_pkg::S_ROOT:   o_cmd = pfa_pkg::CMD_ROOT;
            pfa_pkg::S_ACC:    o_cmd = pfa_pkg::CMD_ACC;
            pfa_pkg::S_FINISH: begin
                if (i_status.last && i_status.out_free) begin
                    o_cmd = pfa_pkg::CMD_EMIT;
                end
            end
            default:           o_cmd = pfa_pkg::CMD_NONE;
        endcase
    end

endmodule

[rtl/pfa_datapath.sv]
// Datapath: vertex store, cross product, squared length, bit-pair square root, accumulator.
module pfa_datapath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  pfa_pkg::t_cmd       i_cmd,
    input  logic signed [15:0]  i_vertex_x,
    input  logic signed [15:0]  i_vertex_y,
    input  logic signed [15:0]  i_vertex_z,
    input  logic signed [15:0]  i_normal_x,
    input  logic signed [15:0]  i_normal_y,
    input  logic signed [15:0]  i_normal_z,
    input  logic                i_last_vertex,
    input  logic                i_out_stall,
    output pfa_pkg::t_dp_status o_status,
    output logic                o_out_valid,
    output logic [42:0]         o_twice_area,
    output logic                o_too_few,
    output logic                o_overflow
);

    pfa_pkg::t_coord w_vin [3];
    pfa_pkg::t_coord w_nin [3];

    pfa_pkg::t_coord r_first [3];
    pfa_pkg::t_coord r_prev  [3];
    pfa_pkg::t_coord r_v     [3];
    pfa_pkg::t_coord r_n     [3];
    pfa_pkg::t_diff  r_a     [3];
    pfa_pkg::t_diff  r_b     [3];
    pfa_pkg::t_prod  r_p     [6];
    pfa_pkg::t_cross r_c     [3];
    pfa_pkg::t_sq    r_sq    [3];
    pfa_pkg::t_dot   r_d     [3];
    pfa_pkg::t_mag   w_mag   [3];

    pfa_pkg::t_rad   r_rad;
    pfa_pkg::t_rem   r_rem;
    pfa_pkg::t_root  r_root;
    pfa_pkg::t_iter  r_iter;
    logic            r_pos;
    logic            r_last;

    pfa_pkg::t_cnt   r_count;
    pfa_pkg::t_acc   r_acc;
    logic            r_ovf;

    logic            r_out_valid;
    pfa_pkg::t_area  r_twice_area;
    logic            r_too_few;
    logic            r_overflow;

    pfa_pkg::t_dot   w_dot;
    pfa_pkg::t_rem   w_rem_sh;
    pfa_pkg::t_rem   w_trial;
    pfa_pkg::t_acc   w_abs;
    logic            w_full;
    logic            w_out_free;

    assign w_vin[0] = i_vertex_x;
    assign w_vin[1] = i_vertex_y;
    assign w_vin[2] = i_vertex_z;
    assign w_nin[0] = i_normal_x;
    assign w_nin[1] = i_normal_y;
    assign w_nin[2] = i_normal_z;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_mag[i] = r_c[i][pfa_pkg::CROSS_W-1] ? pfa_pkg::t_mag'(-r_c[i])
                                                   : pfa_pkg::t_mag'(r_c[i]);
        end
    end

    assign w_dot    = r_d[0] + r_d[1] + r_d[2];
    // next radicand digit pair shifted into the partial remainder
    assign w_rem_sh = {r_rem[pfa_pkg::REM_W-3:0], r_rad[pfa_pkg::RAD_W-1 -: 2]};
    assign w_trial  = {r_root, 2'b01};
    assign w_abs    = r_acc[pfa_pkg::ACC_W-1] ? -r_acc : r_acc;
    assign w_full   = (r_count >= pfa_pkg::CNT_MAX);
    assign w_out_free = !r_out_valid || !i_out_stall;

    assign o_status.full      = w_full;
    assign o_status.forms_tri = (r_count >= pfa_pkg::CNT_TRIANGLE);
    assign o_status.last      = r_last;
    assign o_status.root_done = (r_iter == pfa_pkg::ITER_LAST);
    assign o_status.out_free  = w_out_free;

    // payload registers
    always_ff @(posedge i_clk) begin
        unique case (i_cmd)
            pfa_pkg::CMD_CAPTURE: begin
                r_last <= i_last_vertex;
                for (int i = 0; i < 3; i++) begin
                    r_v[i] <= w_vin[i];
                    r_n[i] <= w_nin[i];
                end
                if (!w_full && (r_count < pfa_pkg::CNT_TRIANGLE)) begin
                    for (int i = 0; i < 3; i++) begin
                        if (r_count == '0) begin
                            r_first[i] <= w_vin[i];
                        end
                        r_prev[i] <= w_vin[i];
                    end
                end
            end
            pfa_pkg::CMD_DIFF: begin
                for (int i = 0; i < 3; i++) begin
                    r_a[i]    <= pfa_pkg::t_diff'(r_first[i]) - pfa_pkg::t_diff'(r_prev[i]);
                    r_b[i]    <= pfa_pkg::t_diff'(r_prev[i]) - pfa_pkg::t_diff'(r_v[i]);
                    r_prev[i] <= r_v[i];
                end
            end
            pfa_pkg::CMD_MUL: begin
                r_p[0] <= pfa_pkg::t_prod'(r_a[1]) * pfa_pkg::t_prod'(r_b[2]);
                r_p[1] <= pfa_pkg::t_prod'(r_a[2]) * pfa_pkg::t_prod'(r_b[1]);
                r_p[2] <= pfa_pkg::t_prod'(r_a[2]) * pfa_pkg::t_prod'(r_b[0]);
                r_p[3] <= pfa_pkg::t_prod'(r_a[0]) * pfa_pkg::t_prod'(r_b[2]);
                r_p[4] <= pfa_pkg::t_prod'(r_a[0]) * pfa_pkg::t_prod'(r_b[1]);
                r_p[5] <= pfa_pkg::t_prod'(r_a[1]) * pfa_pkg::t_prod'(r_b[0]);
            end
            pfa_pkg::CMD_CROSS: begin
                for (int i = 0; i < 3; i++) begin
                    r_c[i] <= pfa_pkg::t_cross'(r_p[2*i]) - pfa_pkg::t_cross'(r_p[2*i+1]);
                end
            end
            pfa_pkg::CMD_SQUARE: begin
                for (int i = 0; i < 3; i++) begin
                    r_sq[i] <= w_mag[i] * w_mag[i];
                    r_d[i]  <= pfa_pkg::t_dot'(r_c[i]) * pfa_pkg::t_dot'(r_n[i]);
                end
            end
            pfa_pkg::CMD_SUM: begin
                r_rad  <= pfa_pkg::t_rad'(r_sq[0]) + pfa_pkg::t_rad'(r_sq[1])
                        + pfa_pkg::t_rad'(r_sq[2]);
                r_pos  <= !w_dot[pfa_pkg::DOT_W-1] && (w_dot != '0);
                r_rem  <= '0;
                r_root <= '0;
            end
            pfa_pkg::CMD_ROOT: begin
                r_rad <= {r_rad[pfa_pkg::RAD_W-3:0], 2'b00};
                if (w_rem_sh >= w_trial) begin
                    r_rem  <= w_rem_sh - w_trial;
                    r_root <= {r_root[pfa_pkg::ROOT_W-2:0], 1'b1};
                end else begin
                    r_rem  <= w_rem_sh;
                    r_root <= {r_root[pfa_pkg::ROOT_W-2:0], 1'b0};
                end
            end
            pfa_pkg::CMD_EMIT: begin
                r_twice_area <= pfa_pkg::t_area'(w_abs);
                r_too_few    <= (r_count < pfa_pkg::CNT_MIN_POLY);
                r_overflow   <= r_ovf;
            end
            default: begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_acc       <= '0;
            r_ovf       <= 1'b0;
            r_iter      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (i_cmd)
                pfa_pkg::CMD_CAPTURE: begin
                    if (w_full) begin
                        r_ovf <= 1'b1;
                    end else if (r_count < pfa_pkg::CNT_TRIANGLE) begin
                        r_count <= r_count + 1'b1;
                    end
                end
                pfa_pkg::CMD_DIFF: r_count <= r_count + 1'b1;
                pfa_pkg::CMD_SUM:  r_iter  <= '0;
                pfa_pkg::CMD_ROOT: r_iter  <= r_iter + 1'b1;
                pfa_pkg::CMD_ACC: begin
                    if (r_pos) begin
                        r_acc <= r_acc + pfa_pkg::t_acc'(r_root);
                    end else begin
                        r_acc <= r_acc - pfa_pkg::t_acc'(r_root);
                    end
                end
                pfa_pkg::CMD_EMIT: begin
                    r_out_valid <= 1'b1;
                    r_count     <= '0;
                    r_acc       <= '0;
                    r_ovf       <= 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_twice_area = r_twice_area;
    assign o_too_few    = r_too_few;
    assign o_overflow   = r_overflow;

endmodule

[rtl/polygon_fan_area.sv]
// Top level of the polygon fan area block: controller plus datapath.
//
// Twice the area of a planar polygon by fan triangulation, roots floored.
// Vertices arrive one item at a time with the polygon normal; the item with
// i_last_vertex set closes the polygon and produces one result item carrying
// twice_area, too_few (fewer than three vertices) and overflow (vertices past
// 256 were dropped). Every vertex from the third on forms a triangle with the
// first and previous vertex: a cross product (differences, a row of 17x17
// multipliers, subtraction), squares and normal dot products, a 36-step
// bit-pair square root retiring one root bit per cycle, a signed accumulate.
// Such a vertex holds the input side through all of these steps; the first
// two vertices and dropped ones pass only through capture and finish. A
// finished result sits in an output register, so the next polygon starts
// while it waits; a final vertex only waits in the finish state if the
// previous result has not yet been taken. No clearing pass after reset.
module polygon_fan_area (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic signed [15:0] i_vertex_x,
    input  logic signed [15:0] i_vertex_y,
    input  logic signed [15:0] i_vertex_z,
    input  logic signed [15:0] i_normal_x,
    input  logic signed [15:0] i_normal_y,
    input  logic signed [15:0] i_normal_z,
    input  logic               i_last_vertex,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [42:0]        o_twice_area,
    output logic               o_too_few,
    output logic               o_overflow
);

    pfa_pkg::t_cmd       w_cmd;
    pfa_pkg::t_dp_status w_status;

    // sequencer: accepts an item only when idle, then steps the datapath
    pfa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (w_status),
        .o_in_stall (o_in_stall),
        .o_cmd      (w_cmd)
    );

    // all arithmetic and polygon state live here
    pfa_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_vertex_x    (i_vertex_x),
        .i_vertex_y    (i_vertex_y),
        .i_vertex_z    (i_vertex_z),
        .i_normal_x    (i_normal_x),
        .i_normal_y    (i_normal_y),
        .i_normal_z    (i_normal_z),
        .i_last_vertex (i_last_vertex),
        .i_out_stall   (i_out_stall),
        .o_status      (w_status),
        .o_out_valid   (o_out_valid),
        .o_twice_area  (o_twice_area),
        .o_too_few     (o_too_few),
        .o_overflow    (o_overflow)
    );

    // a result appears only right after the controller asked for one
    a_out_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(w_cmd == pfa_pkg::CMD_EMIT))
        else $error("result item without emit command");

    // the block is busy in the cycle after taking an item
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input taken twice in a row");

    // a polygon with too few vertices never built up area
    a_too_few_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_too_few) |-> (o_twice_area == '0))
        else $error("nonzero area on short polygon");

    // emit is only ever issued when the output register can take it
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd == pfa_pkg::CMD_EMIT) |-> w_status.out_free)
        else $error("emit overwrote a waiting result");

endmodule

[test/polygon_fan_area_tb.sv]
// Self-checking testbench for polygon_fan_area: directed rows, random polygons, scoreboard.
`timescale 1ns / 1ps

module polygon_fan_area_tb;

    // Random run length, counted in vertices the block actually takes.
    localparam int RANDOM_ITEMS   = 1400;
    // Full 16-bit coordinate range when passed as a span.
    localparam int FULL_SPAN      = 32768;
    // Receiver hold-off used once to back the block up into its input.
    localparam int HOLD_CYCLES    = 1500;
    // Cycles with no handshake on either side before the run is declared hung.
    // Worst honest stretch is the hold-off plus one triangle.
    localparam int WATCHDOG_LIMIT = 20000;
    // Settling time after the last expected result.
    localparam int DRAIN_CYCLES   = 100;
    localparam int SHOW_ERRORS    = 10;

    // One vertex item as it goes onto the input ports.
    typedef struct packed {
        pfa_pkg::t_coord x;
        pfa_pkg::t_coord y;
        pfa_pkg::t_coord z;
        pfa_pkg::t_coord nx;
        pfa_pkg::t_coord ny;
        pfa_pkg::t_coord nz;
        logic            last;
    } t_vtx;

    // One result item as it comes off the output ports.
    typedef struct packed {
        pfa_pkg::t_area area;
        logic           few;
        logic           ovf;
    } t_result;

    // Directed row: vertex plus an optional hand-computed result.
    typedef struct {
        t_vtx    v;
        bit      typed;
        t_result res;
    } t_row;

    // How the vertices of a random polygon are placed.
    typedef enum int {
        SHAPE_SPACE,    // anywhere in the full 3D range, usually non-planar
        SHAPE_PLANE,    // constant z, so every cross product points along z
        SHAPE_CLUSTER,  // tiny coordinates, many repeats and zero triangles
        SHAPE_LINE      // points on one line, every triangle degenerate
    } t_shape;

    localparam t_result NO_RES = '0;

    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic               i_in_valid    = 1'b0;
    logic               o_in_stall;
    pfa_pkg::t_coord    i_vertex_x    = '0;
    pfa_pkg::t_coord    i_vertex_y    = '0;
    pfa_pkg::t_coord    i_vertex_z    = '0;
    pfa_pkg::t_coord    i_normal_x    = '0;
    pfa_pkg::t_coord    i_normal_y    = '0;
    pfa_pkg::t_coord    i_normal_z    = '0;
    logic               i_last_vertex = 1'b0;
    logic               o_out_valid;
    logic               i_out_stall   = 1'b0;
    logic [42:0]        o_twice_area;
    logic               o_too_few;
    logic               o_overflow;

    // Polygon state of the predictor, kept in step with accepted items.
    pfa_pkg::t_coord  poly_first [3];
    pfa_pkg::t_coord  poly_prev  [3];
    pfa_pkg::t_cnt    poly_cnt;
    pfa_pkg::t_acc    poly_acc;
    logic             poly_ovf;

    t_result area_expect_q [$];
    int      err_count     = 0;
    int      vertices_used = 0;
    int      idle_cycles   = 0;
    bit      burst_mode    = 1'b0;  // sender offers back to back
    bit      hold_out      = 1'b0;  // asks the receiver for the long hold-off

    polygon_fan_area i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_vertex_x    (i_vertex_x),
        .i_vertex_y    (i_vertex_y),
        .i_vertex_z    (i_vertex_z),
        .i_normal_x    (i_normal_x),
        .i_normal_y    (i_normal_y),
        .i_normal_z    (i_normal_z),
        .i_last_vertex (i_last_vertex),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_twice_area  (o_twice_area),
        .o_too_few     (o_too_few),
        .o_overflow    (o_overflow)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Floor of the square root, one root bit per pass from the top down.
    // The squared length is below 2^72, so 36 root bits cover it.
    function automatic pfa_pkg::t_root root_floor(input bit [127:0] sq);
        bit [127:0] r;
        bit [127:0] trial;
        r = '0;
        for (int k = pfa_pkg::ROOT_W - 1; k >= 0; k--) begin
            trial = r | (128'd1 << k);
            if (trial * trial <= sq)
                r = trial;
        end
        return pfa_pkg::t_root'(r);
    endfunction

    function automatic void clear_polygon();
        for (int i = 0; i < 3; i++) begin
            poly_first[i] = '0;
            poly_prev[i]  = '0;
        end
        poly_cnt = '0;
        poly_acc = '0;
        poly_ovf = 1'b0;
    endfunction

    // Advance the polygon state by one accepted vertex. taken is low for a
    // vertex dropped past the maximum; emit is high when a result follows.
    function automatic void fan_predict(input t_vtx v, output bit taken,
                                        output bit emit, output t_result res);
        pfa_pkg::t_coord cur [3];
        pfa_pkg::t_coord nrm [3];
        longint          a   [3];
        longint          b   [3];
        longint          c   [3];
        longint          dot;
        bit [127:0]      m;
        bit [127:0]      sq;
        pfa_pkg::t_root  len;
        cur   = '{v.x, v.y, v.z};
        nrm   = '{v.nx, v.ny, v.nz};
        taken = (poly_cnt < pfa_pkg::CNT_MAX);
        if (!taken) begin
            poly_ovf = 1'b1;
        end else begin
            if (poly_cnt == '0) begin
                poly_first = cur;
            end else if (poly_cnt >= pfa_pkg::CNT_TRIANGLE) begin
                // fan triangle (first, previous, current)
                for (int i = 0; i < 3; i++) begin
                    a[i] = longint'(poly_first[i]) - longint'(poly_prev[i]);
                    b[i] = longint'(poly_prev[i]) - longint'(cur[i]);
                end
                c[0] = a[1] * b[2] - a[2] * b[1];
                c[1] = a[2] * b[0] - a[0] * b[2];
                c[2] = a[0] * b[1] - a[1] * b[0];
                sq = '0;
                for (int i = 0; i < 3; i++) begin
                    m  = (c[i] < 0) ? -c[i] : c[i];
                    sq = sq + m * m;
                end
                len = root_floor(sq);
                dot = c[0] * longint'(nrm[0]) + c[1] * longint'(nrm[1])
                    + c[2] * longint'(nrm[2]);
                // zero dot counts as facing away
                if (dot > 0)
                    poly_acc = poly_acc + pfa_pkg::t_acc'(len);
                else
                    poly_acc = poly_acc - pfa_pkg::t_acc'(len);
            end
            poly_prev = cur;
            poly_cnt  = poly_cnt + 1'b1;
        end
        emit = v.last;
        res  = NO_RES;
        if (emit) begin
            if (poly_cnt < pfa_pkg::CNT_MIN_POLY)
                res.few = 1'b1;
            else
                res.area = pfa_pkg::t_area'((poly_acc < 0) ? -poly_acc : poly_acc);
            res.ovf = poly_ovf;
            clear_polygon();
        end
    endfunction

    function automatic pfa_pkg::t_coord rnd_coord(input int span);
        if (span >= FULL_SPAN)
            return pfa_pkg::t_coord'($urandom);
        return pfa_pkg::t_coord'(int'($urandom_range(2 * span)) - span);
    endfunction

    // Sender idle time before the next item: mostly none or short, a few long.
    function automatic int pick_gap();
        int r;
        if (burst_mode)
            return 0;
        r = $urandom_range(99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(3, 1);
        if (r < 97)
            return $urandom_range(12, 4);
        return $urandom_range(100, 30);
    endfunction

    // Offer one vertex, wait for it to be taken, then log what it should
    // produce. A typed row replaces the predicted result with its own.
    task automatic drive_vertex(input t_vtx v, input bit typed, input t_result typed_res);
        int      gap;
        bit      taken;
        bit      emit;
        t_result res;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_vertex_x    <= v.x;
        i_vertex_y    <= v.y;
        i_vertex_z    <= v.z;
        i_normal_x    <= v.nx;
        i_normal_y    <= v.ny;
        i_normal_z    <= v.nz;
        i_last_vertex <= v.last;
        do @(posedge i_clk); while (o_in_stall);
        fan_predict(v, taken, emit, res);
        if (taken)
            vertices_used++;
        if (emit) begin
            if (typed)
                res = typed_res;
            area_expect_q.insert(area_expect_q.size(), res);
        end
    endtask

    function automatic t_vtx vtx(input int x, input int y, input int z,
                                 input int nx, input int ny, input int nz, input bit last);
        return '{pfa_pkg::t_coord'(x), pfa_pkg::t_coord'(y), pfa_pkg::t_coord'(z),
                 pfa_pkg::t_coord'(nx), pfa_pkg::t_coord'(ny), pfa_pkg::t_coord'(nz),
                 last};
    endfunction

    task automatic flag_error(input string msg);
        err_count++;
        if (err_count <= SHOW_ERRORS)
            $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    // Scoreboard: every result taken is matched against the oldest expectation.
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = {o_twice_area, o_too_few, o_overflow};
            if (area_expect_q.size() == 0) begin
                flag_error($sformatf("unexpected result area %0d too_few %0b overflow %0b",
                                     got.area, got.few, got.ovf));
            end else begin
                want = area_expect_q.pop_front();
                if (got.area !== want.area || got.few !== want.few || got.ovf !== want.ovf)
                    flag_error($sformatf({"twice_area exp %0d got %0d, too_few exp %0b got %0b,",
                                          " overflow exp %0b got %0b"},
                                         want.area, got.area, want.few, got.few,
                                         want.ovf, got.ovf));
            end
        end
    end

    // Hang detector: cycles in which neither side moves an item.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Receiver: random stall pattern, plus one long hold-off on request so
    // the output register fills and the block pushes back on its input.
    initial begin
        int r;
        int n;
        forever begin
            if (hold_out) begin
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_out = 1'b0;
            end else begin
                r = $urandom_range(99);
                if (r < 40) begin
                    i_out_stall <= 1'b0;
                    n = $urandom_range(20, 1);
                end else if (r < 50) begin
                    // stretch of free flow
                    i_out_stall <= 1'b0;
                    n = $urandom_range(300, 100);
                end else if (r < 85) begin
                    i_out_stall <= 1'b1;
                    n = $urandom_range(3, 1);
                end else if (r < 96) begin
                    i_out_stall <= 1'b1;
                    n = $urandom_range(15, 4);
                end else begin
                    i_out_stall <= 1'b1;
                    n = $urandom_range(60, 30);
                end
                repeat (n) @(posedge i_clk);
            end
        end
    end

    // Sender: reset, directed rows, then random polygons.
    initial begin
        t_row            dir_rows [$];
        t_vtx            v;
        t_shape          shape;
        int              poly_idx;
        int              len;
        int              span;
        int              r;
        int              stop_at;
        int              zc;
        int              bx, by, bz;
        int              dx, dy, dz;
        int              t;
        pfa_pkg::t_coord nx, ny, nz;

        clear_polygon();
        dir_rows = '{
            // lone vertex closes the polygon: nothing to measure
            '{vtx( 32767, -32768,  32767,  32767, -32768,  32767, 1), 1'b1,
              '{43'd0, 1'b1, 1'b0}},
            // two vertices only
            '{vtx(-32768,  32767, -32768, -32768,  32767, -32768, 0), 1'b0, NO_RES},
            '{vtx(     0,      0,      0,      0,      0,      0, 1), 1'b1,
              '{43'd0, 1'b1, 1'b0}},
            // full-span right triangle in the xy plane, normal along +z:
            // cross product is (0, 0, 65535^2), added
            '{vtx(-32768, -32768, 0, 0, 0, 1, 0), 1'b0, NO_RES},
            '{vtx( 32767, -32768, 0, 0, 0, 1, 0), 1'b0, NO_RES},
            '{vtx(-32768,  32767, 0, 0, 0, 1, 1), 1'b1,
              '{43'd4294836225, 1'b0, 1'b0}},
            // same triangle, normal along -z: subtracted, magnitude unchanged
            '{vtx(-32768, -32768, 0, 0, 0, -32768, 0), 1'b0, NO_RES},
            '{vtx( 32767, -32768, 0, 0, 0, -32768, 0), 1'b0, NO_RES},
            '{vtx(-32768,  32767, 0, 0, 0, -32768, 1), 1'b1,
              '{43'd4294836225, 1'b0, 1'b0}},
            // same triangle, zero normal: zero dot takes the subtract path
            '{vtx(-32768, -32768, 0, 0, 0, 0, 0), 1'b0, NO_RES},
            '{vtx( 32767, -32768, 0, 0, 0, 0, 0), 1'b0, NO_RES},
            '{vtx(-32768,  32767, 0, 0, 0, 0, 1), 1'b1,
              '{43'd4294836225, 1'b0, 1'b0}},
            // collinear points: degenerate triangle, zero area
            '{vtx(0, 0, 0, 7, -3, 1, 0), 1'b0, NO_RES},
            '{vtx(1, 1, 1, 7, -3, 1, 0), 1'b0, NO_RES},
            '{vtx(2, 2, 2, 7, -3, 1, 1), 1'b1, '{43'd0, 1'b0, 1'b0}},
            // square whose normal flips on the closing vertex
            '{vtx(  0,   0, 0, 0, 0,  5, 0), 1'b0, NO_RES},
            '{vtx(100,   0, 0, 0, 0,  5, 0), 1'b0, NO_RES},
            '{vtx(100, 100, 0, 0, 0,  5, 0), 1'b0, NO_RES},
            '{vtx(  0, 100, 0, 0, 0, -5, 1), 1'b0, NO_RES},
            // skew quad over the corners of the range, extreme normal
            '{vtx( 32767, -32768,  32767,  32767, -32768,  32767, 0), 1'b0, NO_RES},
            '{vtx(-32768,  32767, -32768,  32767, -32768,  32767, 0), 1'b0, NO_RES},
            '{vtx( 32767,  32767, -32768,  32767, -32768,  32767, 0), 1'b0, NO_RES},
            '{vtx(-32768, -32768,  32767, -32768,  32767, -32768, 1), 1'b0, NO_RES}
        };

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[k])
            drive_vertex(dir_rows[k].v, dir_rows[k].typed, dir_rows[k].res);

        // Random polygons. Most are short and well formed; some are too short,
        // a few are long, and three go to or past the vertex limit (one ends
        // exactly at it, two end on a dropped vertex).
        stop_at  = vertices_used + RANDOM_ITEMS;
        poly_idx = 0;
        while (vertices_used < stop_at) begin
            poly_idx++;
            if (poly_idx % 15 == 0)
                burst_mode = !burst_mode;
            if (poly_idx == 30)
                hold_out = 1'b1;
            case (poly_idx)
                8: begin
                    len   = pfa_pkg::MAX_VERTICES;
                    shape = SHAPE_PLANE;
                    span  = 1000;
                end
                20: begin
                    len   = pfa_pkg::MAX_VERTICES + 1;
                    shape = SHAPE_CLUSTER;
                    span  = 8;
                end
                45: begin
                    len   = pfa_pkg::MAX_VERTICES + 2 + $urandom_range(6);
                    shape = SHAPE_PLANE;
                    span  = 1000;
                end
                default: begin
                    r = $urandom_range(99);
                    if (r < 15)
                        len = $urandom_range(2, 1);
                    else if (r < 85)
                        len = $urandom_range(8, 3);
                    else
                        len = $urandom_range(40, 9);
                    shape = t_shape'($urandom_range(3));
                    if (shape == SHAPE_CLUSTER)
                        span = 8;
                    else if ($urandom_range(1) != 0)
                        span = FULL_SPAN;
                    else
                        span = $urandom_range(1000, 1);
                end
            endcase

            zc = int'(rnd_coord(FULL_SPAN));
            bx = $urandom_range(2000) - 1000;
            by = $urandom_range(2000) - 1000;
            bz = $urandom_range(2000) - 1000;
            dx = $urandom_range(60) - 30;
            dy = $urandom_range(60) - 30;
            dz = $urandom_range(60) - 30;
            nx = rnd_coord(FULL_SPAN);
            ny = rnd_coord(FULL_SPAN);
            nz = rnd_coord(FULL_SPAN);
            if ($urandom_range(9) == 0) begin
                nx = '0;
                ny = '0;
                nz = '0;
            end

            for (int k = 0; k < len; k++) begin
                case (shape)
                    SHAPE_SPACE: begin
                        v.x = rnd_coord(FULL_SPAN);
                        v.y = rnd_coord(FULL_SPAN);
                        v.z = rnd_coord(FULL_SPAN);
                    end
                    SHAPE_PLANE: begin
                        v.x = rnd_coord(span);
                        v.y = rnd_coord(span);
                        v.z = pfa_pkg::t_coord'(zc);
                    end
                    SHAPE_CLUSTER: begin
                        v.x = rnd_coord(span);
                        v.y = rnd_coord(span);
                        v.z = rnd_coord(span);
                    end
                    default: begin
                        t   = $urandom_range(20);
                        v.x = pfa_pkg::t_coord'(bx + t * dx);
                        v.y = pfa_pkg::t_coord'(by + t * dy);
                        v.z = pfa_pkg::t_coord'(bz + t * dz);
                    end
                endcase
                // the normal may change from one vertex to the next
                if ($urandom_range(9) == 0) begin
                    nx = rnd_coord(FULL_SPAN);
                    ny = rnd_coord(FULL_SPAN);
                    nz = rnd_coord(FULL_SPAN);
                end
                v.nx   = nx;
                v.ny   = ny;
                v.nz   = nz;
                v.last = (k == len - 1);
                drive_vertex(v, 1'b0, NO_RES);
            end
        end
        i_in_valid <= 1'b0;

        while (area_expect_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (err_count == 0 && area_expect_q.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

[polygon_fan_area.f]
rtl/pfa_pkg.sv
rtl/pfa_ctrl.sv
rtl/pfa_datapath.sv
rtl/polygon_fan_area.sv
test/polygon_fan_area_tb.sv
